// File: src/dsr_pkg.sv
`timescale 1ns / 1ps

package dsr_pkg;

	localparam int IDX_W = 6;
	localparam int FRAME_W = 18;
	localparam int LEN_W = 5;
	localparam int INIT_CMDS = 7;

	localparam logic [7:0] REINIT_RESET = 8'd100;
	localparam logic [LEN_W-1:0] CMD_LEN = 5'd12;
	localparam logic [LEN_W-1:0] DATA_LEN = 5'd18;
	localparam logic [2:0] CMD_PREFIX = 3'b100;
	localparam logic [2:0] DATA_PREFIX = 3'b101;
	localparam logic [2:0] LAST_INIT = 3'd6;

	localparam logic REQ_STORE = 1'b0;
	localparam logic REQ_REFRESH = 1'b1;

	typedef struct packed {
		logic       req_type;
		logic [4:0] byte_index;
		logic [7:0] byte_value;
	} item_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_bits;
		logic [LEN_W-1:0]   frame_length;
		logic               last_frame;
	} result_t;

	typedef struct packed {
		logic             rd_en;
		logic [IDX_W-1:0] rd_idx;
		logic             sh_wr_en;
		logic [IDX_W-1:0] sh_idx;
		logic [7:0]       sh_data;
	} scan_cmd_t;

	typedef struct packed {
		logic [7:0] disp;
		logic [7:0] shad;
	} buf_rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_INIT,
		ST_SCAN,
		ST_DRAIN
	} state_t;

	function automatic logic [7:0] init_cmd(input logic [2:0] n);
		logic [7:0] c;
		unique case (n)
			3'd0: c = 8'h00;
			3'd1: c = 8'h20;
			3'd2: c = 8'h18;
			3'd3: c = 8'h01;
			3'd4: c = 8'h03;
			3'd5: c = 8'hA6;
			3'd6: c = 8'h08;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

// File: src/led_driver_dirty_refresh_serializer_unit.sv
`timescale 1ns / 1ps

// Display buffer with a shadow copy of the LED driver contents, sending only changed bytes.
// An item is accepted when start is high and busy is low. A store item writes one byte,
// gives no result, and leaves busy low. A refresh item raises busy and runs a
// small sequencer: seven command frames when the refresh count passes reinit_interval, then
// a scan of every buffer byte through one registered read port and one comparator, one
// byte per cycle, emitting a data frame for each byte that differs from the shadow copy.
// Each frame appears on result for one cycle with result_valid high; the receiver cannot
// stall, so frames come out at up to one per cycle and the final frame of a refresh carries
// last_frame.
// The cfg channel writes reinit_interval when cfg_valid and cfg_ready are both high; cfg_ready
// is always high. Reset clears both buffers and the refresh count, and sets the interval to
// 100. No clearing pass is needed after reset.
module led_driver_dirty_refresh_serializer_unit #(
	parameter int BUFFER_BYTES = 24
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  dsr_pkg::item_t     item,
	output logic               result_valid,
	output dsr_pkg::result_t   result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data
);

	localparam logic [6:0] NBYTES = 7'(BUFFER_BYTES);

	logic [7:0]          interval_q;
	logic                st_en;
	dsr_pkg::scan_cmd_t  scan;
	dsr_pkg::buf_rsp_t   rsp;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			interval_q <= dsr_pkg::REINIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			interval_q <= cfg_data;
		end
	end

	// Stores beyond the buffer are dropped.
	assign st_en = start && !busy && (item.req_type == dsr_pkg::REQ_STORE) &&
		({2'b00, item.byte_index} < NBYTES);

	dsr_buffers #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_buffers (
		.clk     (clk),
		.arst_n  (arst_n),
		.st_en   (st_en),
		.st_idx  ({1'b0, item.byte_index}),
		.st_data (item.byte_value),
		.scan    (scan),
		.rsp     (rsp)
	);

	dsr_ctrl #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.refresh      (item.req_type == dsr_pkg::REQ_REFRESH),
		.interval     (interval_q),
		.rsp          (rsp),
		.scan         (scan),
		.busy         (busy),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// File: src/dsr_buffers.sv
`timescale 1ns / 1ps

module dsr_buffers #(
	parameter int BUFFER_BYTES = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     st_en,
	input  logic [dsr_pkg::IDX_W-1:0] st_idx,
	input  logic [7:0]               st_data,
	input  dsr_pkg::scan_cmd_t       scan,
	output dsr_pkg::buf_rsp_t        rsp
);

	localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

	logic [7:0] disp_mem [BUFFER_BYTES];
	logic [7:0] shad_mem [BUFFER_BYTES];
	logic [BUFFER_BYTES-1:0] dval_q;
	logic [BUFFER_BYTES-1:0] sval_q;

	logic [7:0] disp_s1;
	logic [7:0] shad_s1;
	logic       dv_s1;
	logic       sv_s1;

	logic [AW-1:0] st_a;
	logic [AW-1:0] rd_a;
	logic [AW-1:0] sh_a;

	assign st_a = st_idx[AW-1:0];
	assign rd_a = scan.rd_idx[AW-1:0];
	assign sh_a = scan.sh_idx[AW-1:0];

	// Entries never written read as zero through their valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dval_q <= '0;
			sval_q <= '0;
		end else begin
			if (st_en) begin
				dval_q[st_a] <= 1'b1;
			end
			if (scan.sh_wr_en) begin
				sval_q[sh_a] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (st_en) begin
			disp_mem[st_a] <= st_data;
		end
		if (scan.sh_wr_en) begin
			shad_mem[sh_a] <= scan.sh_data;
		end
		if (scan.rd_en) begin
			disp_s1 <= disp_mem[rd_a];
			shad_s1 <= shad_mem[rd_a];
			dv_s1   <= dval_q[rd_a];
			sv_s1   <= sval_q[rd_a];
		end
	end

	assign rsp.disp = dv_s1 ? disp_s1 : 8'h00;
	assign rsp.shad = sv_s1 ? shad_s1 : 8'h00;

endmodule

// File: src/dsr_ctrl.sv
`timescale 1ns / 1ps

module dsr_ctrl #(
	parameter int BUFFER_BYTES = 24
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                refresh,
	input  logic [7:0]          interval,
	input  dsr_pkg::buf_rsp_t   rsp,
	output dsr_pkg::scan_cmd_t  scan,
	output logic                busy,
	output logic                result_valid,
	output dsr_pkg::result_t    result
);

	localparam logic [dsr_pkg::IDX_W-1:0] LAST_IDX = dsr_pkg::IDX_W'(BUFFER_BYTES - 1);
	localparam logic [dsr_pkg::IDX_W-1:0] IDX_ONE = dsr_pkg::IDX_W'(1);

	dsr_pkg::state_t state_q, state_d;

	logic [7:0]                 count_q;
	logic [2:0]                 init_cnt_q;
	logic [dsr_pkg::IDX_W-1:0]  rd_idx_q;
	logic [dsr_pkg::IDX_W-1:0]  cmp_idx_s1;
	logic                       cmp_v_s1;

	logic                         pend_v_q;
	logic [dsr_pkg::FRAME_W-1:0]  pend_bits_q;
	logic [dsr_pkg::LEN_W-1:0]    pend_len_q;
	logic                         out_v_q;
	dsr_pkg::result_t             out_q;

	logic                         accept;
	logic [8:0]                   count_next;
	logic                         init_hit;
	logic                         differ;
	logic                         new_v;
	logic [dsr_pkg::FRAME_W-1:0]  new_bits;
	logic [dsr_pkg::LEN_W-1:0]    new_len;
	logic                         flush;
	logic [6:0]                   nib_addr;

	assign busy       = (state_q != dsr_pkg::ST_IDLE);
	assign accept     = start && !busy && refresh;
	assign count_next = {1'b0, count_q} + 9'd1;
	assign init_hit   = count_next > {1'b0, interval};
	assign differ     = cmp_v_s1 && (rsp.disp != rsp.shad);
	assign nib_addr   = {cmp_idx_s1, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dsr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		new_v    = 1'b0;
		new_bits = '0;
		new_len  = dsr_pkg::CMD_LEN;
		flush    = 1'b0;
		scan     = '0;

		unique case (state_q)
			dsr_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = init_hit ? dsr_pkg::ST_INIT : dsr_pkg::ST_SCAN;
				end
			end
			dsr_pkg::ST_INIT: begin
				new_v    = 1'b1;
				new_bits = {6'b0, dsr_pkg::CMD_PREFIX, dsr_pkg::init_cmd(init_cnt_q), 1'b0};
				new_len  = dsr_pkg::CMD_LEN;
				if (init_cnt_q == dsr_pkg::LAST_INIT) begin
					state_d = dsr_pkg::ST_SCAN;
				end
			end
			dsr_pkg::ST_SCAN: begin
				scan.rd_en  = 1'b1;
				scan.rd_idx = rd_idx_q;
				if (rd_idx_q == LAST_IDX) begin
					state_d = dsr_pkg::ST_DRAIN;
				end
			end
			dsr_pkg::ST_DRAIN: begin
				if (!cmp_v_s1) begin
					flush   = 1'b1;
					state_d = dsr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dsr_pkg::ST_IDLE;
			end
		endcase

		// The compare stage runs in the cycle after each read, so its last compare falls in the drain state.
		if (differ) begin
			new_v         = 1'b1;
			new_bits      = {dsr_pkg::DATA_PREFIX, nib_addr, rsp.disp[3:0], rsp.disp[7:4]};
			new_len       = dsr_pkg::DATA_LEN;
			scan.sh_wr_en = 1'b1;
			scan.sh_idx   = cmp_idx_s1;
			scan.sh_data  = rsp.disp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			init_cnt_q <= '0;
			rd_idx_q   <= '0;
			cmp_v_s1   <= 1'b0;
			pend_v_q   <= 1'b0;
			out_v_q    <= 1'b0;
		end else begin
			if (accept) begin
				count_q    <= init_hit ? 8'd0 : count_next[7:0];
				init_cnt_q <= '0;
				rd_idx_q   <= '0;
			end
			if (state_q == dsr_pkg::ST_INIT) begin
				init_cnt_q <= init_cnt_q + 3'd1;
			end
			if (scan.rd_en) begin
				rd_idx_q <= rd_idx_q + IDX_ONE;
			end
			cmp_v_s1 <= scan.rd_en;

			// A frame is held back in a pending register so the final one can carry its last flag.
			out_v_q <= 1'b0;
			if (new_v) begin
				out_v_q  <= pend_v_q;
				pend_v_q <= 1'b1;
			end else if (flush) begin
				out_v_q  <= pend_v_q;
				pend_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (scan.rd_en) begin
			cmp_idx_s1 <= rd_idx_q;
		end
		if (new_v) begin
			pend_bits_q <= new_bits;
			pend_len_q  <= new_len;
		end
		if (new_v || flush) begin
			out_q.frame_bits   <= pend_bits_q;
			out_q.frame_length <= pend_len_q;
			out_q.last_frame   <= flush;
		end
	end

	assign result_valid = out_v_q;
	assign result       = out_q;

endmodule
